// ===== rtl/spb_pkg.sv =====
`default_nettype none

package spb_pkg;

    localparam int unsigned MODEL_W  = 24;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    // datapath widths
    localparam int unsigned PROD_W = 48;   // model x 25-bit unsigned coefficient
    localparam int unsigned U_W    = 49;   // denormalized value before clamp
    localparam int unsigned PL_W   = 41;   // weight x low half of product
    localparam int unsigned PH_W   = 42;   // weight x high half of product
    localparam int unsigned Q_W    = 25;   // (one - weight) x original byte
    localparam int unsigned ACC_W  = 66;   // blend accumulator

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // deviation*255 and mean*255, both in Q.16; red, green, blue
    localparam logic [GAIN_W-1:0] DEV_K [NUM_CH] = '{24'd3826975, 24'd3743416, 24'd3760128};
    localparam logic [GAIN_W-1:0] MEAN_K [NUM_CH] = '{24'd8105165, 24'd7620526, 24'd6784942};

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_GAIN   = 2'd1,
        REG_WEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                mode;
        logic [GAIN_W-1:0]   gain;
        logic [WEIGHT_W-1:0] w;      // saturated to one
        logic [WEIGHT_W-1:0] inv;    // one - w
    } cfg_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic load_d;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spb_apb_regs.sv =====
`default_nettype none

module spb_apb_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [spb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [spb_pkg::DATA_W-1:0]  pwdata,
    output logic      [spb_pkg::DATA_W-1:0]  prdata,
    output spb_pkg::cfg_t                    cfg
);

    logic                             mode_reg, mode_next;
    logic [spb_pkg::GAIN_W-1:0]       gain_reg, gain_next;
    logic [spb_pkg::WEIGHT_W-1:0]     weight_reg, weight_next;
    logic                             wr_en;
    spb_pkg::reg_idx_t                idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = spb_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        mode_next   = mode_reg;
        gain_next   = gain_reg;
        weight_next = weight_reg;
        prdata      = '0;
        unique case (idx)
            spb_pkg::REG_MODE:
            begin
                prdata = {{(spb_pkg::DATA_W-1){1'b0}}, mode_reg};
                if (wr_en)
                begin
                    mode_next = pwdata[0];
                end
            end
            spb_pkg::REG_GAIN:
            begin
                prdata = {{(spb_pkg::DATA_W-spb_pkg::GAIN_W){1'b0}}, gain_reg};
                if (wr_en)
                begin
                    gain_next = pwdata[spb_pkg::GAIN_W-1:0];
                end
            end
            spb_pkg::REG_WEIGHT:
            begin
                prdata = {{(spb_pkg::DATA_W-spb_pkg::WEIGHT_W){1'b0}}, weight_reg};
                if (wr_en)
                begin
                    weight_next = pwdata[spb_pkg::WEIGHT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            gain_reg   <= 24'd256;
            weight_reg <= spb_pkg::WEIGHT_ONE;
        end
        else
        begin
            mode_reg   <= mode_next;
            gain_reg   <= gain_next;
            weight_reg <= weight_next;
        end
    end

    always_comb
    begin
        cfg.mode = mode_reg;
        cfg.gain = gain_reg;
        cfg.w    = (weight_reg > spb_pkg::WEIGHT_ONE) ? spb_pkg::WEIGHT_ONE : weight_reg;
        cfg.inv  = spb_pkg::WEIGHT_ONE - cfg.w;
    end

endmodule

`default_nettype wire

// ===== rtl/spb_pipe_ctrl.sv =====
`default_nettype none

module spb_pipe_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output spb_pkg::pipe_ctl_t ctl
);

    // stage A..D valid bits, index 0 is A
    logic [3:0] valid_reg, valid_next;
    logic [3:0] rdy;

    // a stage loads when empty or when the one after it moves
    always_comb
    begin
        rdy[3] = !valid_reg[3] || !out_stall;
        rdy[2] = !valid_reg[2] || rdy[3];
        rdy[1] = !valid_reg[1] || rdy[2];
        rdy[0] = !valid_reg[0] || rdy[1];

        valid_next[0] = rdy[0] ? in_valid     : valid_reg[0];
        valid_next[1] = rdy[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = rdy[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = rdy[3] ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall   = !rdy[0];
    assign out_valid  = valid_reg[3];
    assign ctl.load_a = rdy[0];
    assign ctl.load_b = rdy[1];
    assign ctl.load_c = rdy[2];
    assign ctl.load_d = rdy[3];

    logic in_acc;
    logic out_take;
    assign in_acc   = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (valid_reg == 4'b1111))
        else $error("input stalled while the pipeline has a bubble");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !out_take) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("accepted word not counted in pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_acc && out_take) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) - 1))
        else $error("delivered word not removed from pipeline");

endmodule

`default_nettype wire

// ===== rtl/spb_channel.sv =====
`default_nettype none

module spb_channel
#(
    parameter int unsigned FRAC_BITS = 14,
    parameter int unsigned CHAN      = 0
)
(
    input  wire logic                                clk,
    input  wire spb_pkg::pipe_ctl_t                  ctl,
    input  wire spb_pkg::cfg_t                       cfg,
    input  wire logic signed [spb_pkg::MODEL_W-1:0]  model,
    input  wire logic        [spb_pkg::BYTE_W-1:0]   orig,
    output logic             [spb_pkg::BYTE_W-1:0]   result
);

    localparam int unsigned U_W      = spb_pkg::U_W;
    localparam int unsigned ACC_W    = spb_pkg::ACC_W;
    localparam int unsigned PROD_W   = spb_pkg::PROD_W;
    localparam int unsigned PL_W     = spb_pkg::PL_W;
    localparam int unsigned PH_W     = spb_pkg::PH_W;
    localparam int unsigned Q_W      = spb_pkg::Q_W;
    localparam int unsigned HALF_W   = PROD_W / 2;
    localparam int unsigned FRAC_NB  = FRAC_BITS + 16;
    localparam int unsigned FRAC_ACC = FRAC_BITS + 24;
    localparam int unsigned SH_ORIG  = FRAC_BITS + 8;

    localparam logic [U_W-1:0] MEAN_TERM =
        {{(U_W-spb_pkg::GAIN_W){1'b0}}, spb_pkg::MEAN_K[CHAN]} << FRAC_BITS;
    localparam logic [U_W-1:0]   NB_TOP   = U_W'(255) << FRAC_NB;
    localparam logic [U_W-1:0]   NB_HALF  = U_W'(1) << (FRAC_NB - 1);
    localparam logic [ACC_W-1:0] ACC_TOP  = ACC_W'(255) << FRAC_ACC;
    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_ACC - 1);

    // stage A: model x (gain or deviation), (one - w) x orig
    logic [spb_pkg::GAIN_W-1:0]   coef;
    logic signed [PROD_W-1:0]     prod_next, prod_a_reg;
    logic [Q_W-1:0]               q_next, q_a_reg;

    assign coef      = cfg.mode ? spb_pkg::DEV_K[CHAN] : cfg.gain;
    assign prod_next = model * $signed({1'b0, coef});
    assign q_next    = cfg.inv * orig;

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            prod_a_reg <= prod_next;
            q_a_reg    <= q_next;
        end
    end

    // stage B: plain splits w x product in two halves; normalized adds mean, clamps and rounds
    logic        [HALF_W-1:0]        sl;
    logic signed [HALF_W-1:0]        sh;
    logic        [PL_W-1:0]          pl_next, pl_b_reg;
    logic signed [PH_W-1:0]          ph_next, ph_b_reg;
    logic signed [U_W-1:0]           u, u_round;
    logic        [spb_pkg::BYTE_W-1:0] nb_next, nb_b_reg;
    logic        [Q_W-1:0]           q_b_reg;

    assign sl      = prod_a_reg[HALF_W-1:0];
    assign sh      = prod_a_reg[PROD_W-1:HALF_W];
    assign pl_next = cfg.w * sl;
    assign ph_next = $signed({1'b0, cfg.w}) * sh;
    assign u       = $signed({prod_a_reg[PROD_W-1], prod_a_reg}) + $signed(MEAN_TERM);
    assign u_round = u + $signed(NB_HALF);

    always_comb
    begin
        if (u <= 0)
        begin
            nb_next = '0;
        end
        else if (u >= $signed(NB_TOP))
        begin
            nb_next = 8'd255;
        end
        else
        begin
            nb_next = u_round[FRAC_NB+7:FRAC_NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_b)
        begin
            pl_b_reg <= pl_next;
            ph_b_reg <= ph_next;
            nb_b_reg <= nb_next;
            q_b_reg  <= q_a_reg;
        end
    end

    // stage C: blend sum, both modes aligned to FRAC_ACC fraction bits
    logic signed [ACC_W-1:0] ph_ext, pl_ext, q_ext, norm_acc, acc_next, acc_c_reg;
    logic        [Q_W-1:0]   norm_mix;

    assign ph_ext   = $signed({{(ACC_W-PH_W){ph_b_reg[PH_W-1]}}, ph_b_reg}) <<< HALF_W;
    assign pl_ext   = $signed({{(ACC_W-PL_W){1'b0}}, pl_b_reg});
    assign q_ext    = $signed({{(ACC_W-Q_W){1'b0}}, q_b_reg}) <<< SH_ORIG;
    assign norm_mix = cfg.w * nb_b_reg + q_b_reg;
    assign norm_acc = $signed({{(ACC_W-Q_W){1'b0}}, norm_mix}) <<< SH_ORIG;
    assign acc_next = cfg.mode ? norm_acc : (ph_ext + pl_ext + q_ext);

    always_ff @(posedge clk)
    begin
        if (ctl.load_c)
        begin
            acc_c_reg <= acc_next;
        end
    end

    // stage D: clamp to 0..255, round half up
    logic signed [ACC_W-1:0]           acc_round;
    logic        [spb_pkg::BYTE_W-1:0] res_next, res_d_reg;

    assign acc_round = acc_c_reg + $signed(ACC_HALF);

    always_comb
    begin
        if (acc_c_reg <= 0)
        begin
            res_next = '0;
        end
        else if (acc_c_reg >= $signed(ACC_TOP))
        begin
            res_next = 8'd255;
        end
        else
        begin
            res_next = acc_round[FRAC_ACC+7:FRAC_ACC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_d)
        begin
            res_d_reg <= res_next;
        end
    end

    assign result = res_d_reg;

endmodule

`default_nettype wire

// ===== rtl/stylized_pixel_blend_top.sv =====
// An accepted input word passes through the registers of stages A, B, C and D.
// Throughput: one pixel per clock unless in_stall is raised; four register stages per
// channel, each holding one rank of multiplies (24x25, or 17x24 beside 18x24) or one
// wide add and clamp. A stalled output holds its word; earlier stages keep filling
// until all four are full. Reset (rst_n low, asynchronous) empties the pipeline and
// loads mode 0, gain 256 and mix weight 65536.
`default_nettype none

module stylized_pixel_blend_top
#(
    parameter int unsigned MODEL_FRAC_BITS = 14
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [spb_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [spb_pkg::DATA_W-1:0]         pwdata,
    output logic      [spb_pkg::DATA_W-1:0]         prdata,
    output logic                                    pready,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [spb_pkg::MODEL_W-1:0] model_red,
    input  wire logic signed [spb_pkg::MODEL_W-1:0] model_green,
    input  wire logic signed [spb_pkg::MODEL_W-1:0] model_blue,
    input  wire logic [spb_pkg::BYTE_W-1:0]         orig_blue,
    input  wire logic [spb_pkg::BYTE_W-1:0]         orig_green,
    input  wire logic [spb_pkg::BYTE_W-1:0]         orig_red,
    input  wire logic [spb_pkg::BYTE_W-1:0]         orig_alpha,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [spb_pkg::BYTE_W-1:0]         out_blue,
    output logic      [spb_pkg::BYTE_W-1:0]         out_green,
    output logic      [spb_pkg::BYTE_W-1:0]         out_red,
    output logic      [spb_pkg::BYTE_W-1:0]         out_alpha
);

    spb_pkg::cfg_t      cfg;
    spb_pkg::pipe_ctl_t ctl;

    assign pready = 1'b1;

    spb_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    spb_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    spb_channel #(.FRAC_BITS(MODEL_FRAC_BITS), .CHAN(spb_pkg::CH_BLUE)) u_blue
    (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg),
        .model  (model_blue),
        .orig   (orig_blue),
        .result (out_blue)
    );

    spb_channel #(.FRAC_BITS(MODEL_FRAC_BITS), .CHAN(spb_pkg::CH_GREEN)) u_green
    (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg),
        .model  (model_green),
        .orig   (orig_green),
        .result (out_green)
    );

    spb_channel #(.FRAC_BITS(MODEL_FRAC_BITS), .CHAN(spb_pkg::CH_RED)) u_red
    (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg),
        .model  (model_red),
        .orig   (orig_red),
        .result (out_red)
    );

    // alpha rides alongside the channel stages
    logic [spb_pkg::BYTE_W-1:0] alpha_a_reg, alpha_b_reg, alpha_c_reg, alpha_d_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            alpha_a_reg <= orig_alpha;
        end
        if (ctl.load_b)
        begin
            alpha_b_reg <= alpha_a_reg;
        end
        if (ctl.load_c)
        begin
            alpha_c_reg <= alpha_b_reg;
        end
        if (ctl.load_d)
        begin
            alpha_d_reg <= alpha_c_reg;
        end
    end

    assign out_alpha = alpha_d_reg;

endmodule

`default_nettype wire
